@@ sv/mmpr_pkg.sv @@
// Shared types and constants for the multicast partition router.
package mmpr_pkg;

   localparam int unsigned MASK_W     = 64;
   localparam int unsigned COORD_W    = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned PT_COUNT   = 9;

   localparam int unsigned PT_N  = 0;
   localparam int unsigned PT_NE = 1;
   localparam int unsigned PT_E  = 2;
   localparam int unsigned PT_SE = 3;
   localparam int unsigned PT_S  = 4;
   localparam int unsigned PT_SW = 5;
   localparam int unsigned PT_W  = 6;
   localparam int unsigned PT_NW = 7;
   localparam int unsigned PT_L  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_Y = 1'b1;

   typedef logic [PT_COUNT-1:0]             part_hot_type;
   typedef logic [PT_COUNT-1:0][MASK_W-1:0] sect_masks_type;

   typedef struct packed {
      logic [MASK_W-1:0] east;
      logic [MASK_W-1:0] north;
      logic [MASK_W-1:0] west;
      logic [MASK_W-1:0] south;
      logic [MASK_W-1:0] loc;
      logic              err;
   } route_result_type;

endpackage

@@ sv/mmpr_lane.sv @@
// One destination lane: places a single mesh node into its partition.
module mmpr_lane import mmpr_pkg::*; #(
   parameter int LANE_X = 0,
   parameter int LANE_Y = 0
) (
   input  logic [COORD_W-1:0] own_x,
   input  logic [COORD_W-1:0] own_y,
   input  logic               dest_bit,
   output part_hot_type       part_hot
);

   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;

   assign dx = COORD_W'(LANE_X);
   assign dy = COORD_W'(LANE_Y);

   always_comb begin
      part_hot = '0;
      if (dy > own_y) begin
         if (dx > own_x)       part_hot[PT_NE] = dest_bit;
         else if (dx == own_x) part_hot[PT_N]  = dest_bit;
         else                  part_hot[PT_NW] = dest_bit;
      end else if (dy == own_y) begin
         if (dx > own_x)       part_hot[PT_E]  = dest_bit;
         else if (dx < own_x)  part_hot[PT_W]  = dest_bit;
         else                  part_hot[PT_L]  = dest_bit;
      end else begin
         if (dx > own_x)       part_hot[PT_SE] = dest_bit;
         else if (dx == own_x) part_hot[PT_S]  = dest_bit;
         else                  part_hot[PT_SW] = dest_bit;
      end
   end

endmodule

@@ sv/mmpr_merge.sv @@
// Merge stage: port enable rules and assignment of sectors to ports.
module mmpr_merge import mmpr_pkg::*; (
   input  sect_masks_type   sect,
   output route_result_type result
);

   logic [PT_COUNT-1:0] p;
   logic fe, fn, fw, fs, fl;

   always_comb begin
      for (int k = 0; k < PT_COUNT; k++) p[k] = |sect[k];
   end

   assign fe = p[PT_E] | (p[PT_SE] & ~p[PT_S] & ~p[PT_SW]);
   assign fn = p[PT_N] | (p[PT_NE] & (~p[PT_E] | (~p[PT_SW] & p[PT_SE])))
               | (p[PT_NE] & p[PT_NW]);
   assign fw = p[PT_W] | (p[PT_NW] & ~p[PT_N] & ~p[PT_NE]);
   assign fs = p[PT_S] | (p[PT_SW] & (~p[PT_W] | (~p[PT_NE] & p[PT_SW])))
               | (p[PT_SW] & p[PT_SE]);
   assign fl = p[PT_L];

   always_comb begin
      result = '0;
      if (fn) result.north |= sect[PT_N]; else if (p[PT_N]) result.err = 1'b1;
      if (fs) result.south |= sect[PT_S]; else if (p[PT_S]) result.err = 1'b1;
      if (fe) result.east  |= sect[PT_E]; else if (p[PT_E]) result.err = 1'b1;
      if (fw) result.west  |= sect[PT_W]; else if (p[PT_W]) result.err = 1'b1;
      if (fl) result.loc   |= sect[PT_L]; else if (p[PT_L]) result.err = 1'b1;

      // diagonals prefer north/south
      if (fn)           result.north |= sect[PT_NE];
      else if (fe)      result.east  |= sect[PT_NE];
      else if (p[PT_NE]) result.err  = 1'b1;

      if (fn)           result.north |= sect[PT_NW];
      else if (fw)      result.west  |= sect[PT_NW];
      else if (p[PT_NW]) result.err  = 1'b1;

      if (fs)           result.south |= sect[PT_SE];
      else if (fe)      result.east  |= sect[PT_SE];
      else if (p[PT_SE]) result.err  = 1'b1;

      if (fs)           result.south |= sect[PT_SW];
      else if (fw)      result.west  |= sect[PT_SW];
      else if (p[PT_SW]) result.err  = 1'b1;
   end

endmodule

@@ sv/mesh_multicast_partition_router.sv @@
// Top level: multicast output-port splitter for a mesh router.
// Pipeline: an accepted start passes the lane stage (sect_ff), then the merge stage (result_ff), to rsp_valid.
// Throughput: one transaction per cycle; busy is never raised.
// Datapath: one lane per mesh node, then one merge stage; no stalls.
// Reset: synchronous active high; clears pipeline valids and own_x/own_y.
module mesh_multicast_partition_router import mmpr_pkg::*; #(
   parameter int MESH_COLS = 8,
   parameter int MESH_ROWS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [MASK_W-1:0]    req_dest_mask,
   output logic                 rsp_valid,
   output logic [MASK_W-1:0]    rsp_east_dests,
   output logic [MASK_W-1:0]    rsp_north_dests,
   output logic [MASK_W-1:0]    rsp_west_dests,
   output logic [MASK_W-1:0]    rsp_south_dests,
   output logic [MASK_W-1:0]    rsp_local_dests,
   output logic                 rsp_route_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   localparam int NODE_COUNT = MESH_ROWS * MESH_COLS;

   logic [COORD_W-1:0] own_x_ff, own_x_in;
   logic [COORD_W-1:0] own_y_ff, own_y_in;
   sect_masks_type     sect_ff, sect_in;
   logic               s1_valid_ff, s1_valid_in;
   route_result_type   result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   part_hot_type       lane_hot [MASK_W];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      own_x_in = own_x_ff;
      own_y_in = own_y_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OWN_X: own_x_in = csr_wdata;
            CSR_OWN_Y: own_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   genvar i;
   generate
      for (i = 0; i < MASK_W; i++) begin : g_lane
         if (i < NODE_COUNT) begin : g_node
            mmpr_lane #(
               .LANE_X(i % MESH_COLS),
               .LANE_Y(i / MESH_COLS)
            ) u_lane (
               .own_x   (own_x_ff),
               .own_y   (own_y_ff),
               .dest_bit(req_dest_mask[i]),
               .part_hot(lane_hot[i])
            );
         end else begin : g_off
            assign lane_hot[i] = '0;
         end
      end
   endgenerate

   always_comb begin
      for (int k = 0; k < PT_COUNT; k++) begin
         for (int b = 0; b < MASK_W; b++) sect_in[k][b] = lane_hot[b][k];
      end
   end

   assign s1_valid_in  = start && !busy;
   assign rsp_valid_in = s1_valid_ff;

   mmpr_merge u_merge (
      .sect  (sect_ff),
      .result(result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         own_x_ff     <= '0;
         own_y_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         own_x_ff     <= own_x_in;
         own_y_ff     <= own_y_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sect_ff   <= sect_in;
      result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_east_dests  = result_ff.east;
   assign rsp_north_dests = result_ff.north;
   assign rsp_west_dests  = result_ff.west;
   assign rsp_south_dests = result_ff.south;
   assign rsp_local_dests = result_ff.loc;
   assign rsp_route_error = result_ff.err;

endmodule

@@ verif/tb_top.sv @@
// Testbench for the mesh multicast partition router against a local predictor.
`timescale 1ns / 1ps

module tb_top;
   import mmpr_pkg::*;

   localparam int MESH_COLS    = 8;
   localparam int MESH_ROWS    = 8;
   localparam int NODES        = MESH_COLS * MESH_ROWS;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int PRINT_CAP    = 40;
   localparam int PHASE_ITEMS  = 158;

   typedef struct {
      logic [MASK_W-1:0] mask;
      int unsigned       gap;
      bit                drain;
   } mask_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [MASK_W-1:0]    req_dest_mask = '0;
   logic                 rsp_valid;
   logic [MASK_W-1:0]    rsp_east_dests;
   logic [MASK_W-1:0]    rsp_north_dests;
   logic [MASK_W-1:0]    rsp_west_dests;
   logic [MASK_W-1:0]    rsp_south_dests;
   logic [MASK_W-1:0]    rsp_local_dests;
   logic                 rsp_route_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_wdata = '0;

   logic [COORD_W-1:0]   cfg_own_x = '0;
   logic [COORD_W-1:0]   cfg_own_y = '0;
   mask_req_type         mask_queue[$];
   mask_req_type         cur_item;
   bit                   have_item = 1'b0;
   route_result_type     expected_route[int];
   int                   n_sent = 0;
   int                   n_recv = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   mesh_multicast_partition_router #(
      .MESH_COLS(MESH_COLS),
      .MESH_ROWS(MESH_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_dest_mask(req_dest_mask),
      .rsp_valid(rsp_valid),
      .rsp_east_dests(rsp_east_dests),
      .rsp_north_dests(rsp_north_dests),
      .rsp_west_dests(rsp_west_dests),
      .rsp_south_dests(rsp_south_dests),
      .rsp_local_dests(rsp_local_dests),
      .rsp_route_error(rsp_route_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned partition_of(int x, int y, int ox, int oy);
      if (y > oy) begin
         if (x > ox) return PT_NE;
         if (x == ox) return PT_N;
         return PT_NW;
      end
      if (y == oy) begin
         if (x > ox) return PT_E;
         if (x < ox) return PT_W;
         return PT_L;
      end
      if (x > ox) return PT_SE;
      if (x == ox) return PT_S;
      return PT_SW;
   endfunction

   function automatic route_result_type predict_route(logic [MASK_W-1:0] mask,
         logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
      sect_masks_type   sect;
      part_hot_type     p;
      logic             fe, fn, fw, fs, fl;
      route_result_type r;
      sect = '0;
      r = '0;
      for (int i = 0; i < NODES && i < MASK_W; i++) begin
         if (mask[i])
            sect[partition_of(i % MESH_COLS, i / MESH_COLS, int'(ox), int'(oy))][i] = 1'b1;
      end
      for (int k = 0; k < PT_COUNT; k++) p[k] = |sect[k];

      fe = p[PT_E] | (p[PT_SE] & ~p[PT_S] & ~p[PT_SW]);
      fn = p[PT_N] | (p[PT_NE] & (~p[PT_E] | (~p[PT_SW] & p[PT_SE])))
           | (p[PT_NE] & p[PT_NW]);
      fw = p[PT_W] | (p[PT_NW] & ~p[PT_N] & ~p[PT_NE]);
      fs = p[PT_S] | (p[PT_SW] & (~p[PT_W] | (~p[PT_NE] & p[PT_SW])))
           | (p[PT_SW] & p[PT_SE]);
      fl = p[PT_L];

      if (fn) r.north |= sect[PT_N]; else if (p[PT_N]) r.err = 1'b1;
      if (fs) r.south |= sect[PT_S]; else if (p[PT_S]) r.err = 1'b1;
      if (fe) r.east  |= sect[PT_E]; else if (p[PT_E]) r.err = 1'b1;
      if (fw) r.west  |= sect[PT_W]; else if (p[PT_W]) r.err = 1'b1;
      if (fl) r.loc   |= sect[PT_L]; else if (p[PT_L]) r.err = 1'b1;

      // diagonals go north/south first
      if (fn) r.north |= sect[PT_NE];
      else if (fe) r.east |= sect[PT_NE];
      else if (p[PT_NE]) r.err = 1'b1;
      if (fn) r.north |= sect[PT_NW];
      else if (fw) r.west |= sect[PT_NW];
      else if (p[PT_NW]) r.err = 1'b1;
      if (fs) r.south |= sect[PT_SE];
      else if (fe) r.east |= sect[PT_SE];
      else if (p[PT_SE]) r.err = 1'b1;
      if (fs) r.south |= sect[PT_SW];
      else if (fw) r.west |= sect[PT_SW];
      else if (p[PT_SW]) r.err = 1'b1;
      return r;
   endfunction

   function automatic logic [MASK_W-1:0] node_bit(int x, int y);
      logic [MASK_W-1:0] m;
      m = '0;
      m[y * MESH_COLS + x] = 1'b1;
      return m;
   endfunction

   function automatic logic [MASK_W-1:0] make_dest_mask();
      logic [MASK_W-1:0] m;
      logic [8:0]        pick;
      int                kind;
      m = '0;
      kind = $urandom_range(0, 19);
      if (kind < 5) begin
         m = {$urandom, $urandom};
      end else if (kind < 9) begin
         repeat ($urandom_range(1, 4)) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
      end else if (kind < 19) begin
         pick = $urandom_range(1, 511);
         for (int i = 0; i < NODES && i < MASK_W; i++) begin
            if (pick[partition_of(i % MESH_COLS, i / MESH_COLS,
                                  int'(cfg_own_x), int'(cfg_own_y))]
                  && $urandom_range(0, 3) == 0)
               m[i] = 1'b1;
         end
      end
      return m;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= PRINT_CAP) $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, int idx, logic [MASK_W-1:0] got,
         logic [MASK_W-1:0] want);
      if (got !== want)
         report_error($sformatf("transaction %0d %s got %h want %h", idx, name, got, want));
   endtask

   task automatic queue_mask(logic [MASK_W-1:0] mask, int unsigned gap, bit drain);
      mask_req_type it;
      it.mask = mask;
      it.gap = gap;
      it.drain = drain;
      mask_queue.push_back(it);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (mask_queue.size() != 0 || have_item || start || n_sent != n_recv);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_OWN_X) cfg_own_x = data;
      else cfg_own_y = data;
   endtask

   // driver
   always @(posedge clock) begin
      logic launch;
      launch = 1'b0;
      if (reset) begin
         start <= 1'b0;
         req_dest_mask <= '0;
         n_sent <= 0;
      end else begin
         if (start && !busy) begin
            expected_route[n_sent] = predict_route(req_dest_mask, cfg_own_x, cfg_own_y);
            n_sent <= n_sent + 1;
         end
         if (!start || !busy) begin
            if (!have_item && mask_queue.size() != 0) begin
               cur_item = mask_queue.pop_front();
               have_item = 1'b1;
            end
            if (have_item) begin
               if (cur_item.gap != 0) cur_item.gap--;
               else if (!cur_item.drain || (n_sent == n_recv && !(start && !busy)))
                  launch = 1'b1;
            end
            if (launch) begin
               req_dest_mask <= cur_item.mask;
               have_item = 1'b0;
            end
            start <= launch;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      route_result_type want;
      if (reset) begin
         n_recv <= 0;
      end else if (rsp_valid) begin
         if (n_recv >= n_sent) begin
            report_error("result with no transaction waiting");
         end else begin
            want = expected_route[n_recv];
            expected_route.delete(n_recv);
            check_field("east_dests", n_recv, rsp_east_dests, want.east);
            check_field("north_dests", n_recv, rsp_north_dests, want.north);
            check_field("west_dests", n_recv, rsp_west_dests, want.west);
            check_field("south_dests", n_recv, rsp_south_dests, want.south);
            check_field("local_dests", n_recv, rsp_local_dests, want.loc);
            check_field("route_error", n_recv, MASK_W'(rsp_route_error), MASK_W'(want.err));
            n_recv <= n_recv + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [COORD_W-1:0] px[6];
      logic [COORD_W-1:0] py[6];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coordinates (0,0)
      queue_mask('0, 0, 1'b0);
      queue_mask('1, 0, 1'b0);
      queue_mask(node_bit(0, 0), 1, 1'b0);
      queue_mask(node_bit(7, 7), 0, 1'b0);
      queue_mask(node_bit(1, 0), 2, 1'b0);
      queue_mask(node_bit(0, 1), 0, 1'b0);
      queue_mask(node_bit(1, 1), 0, 1'b0);
      wait_idle();

      // central router (3,4): each sector alone, then rule corners
      write_csr(CSR_OWN_X, 3'd3);
      write_csr(CSR_OWN_Y, 3'd4);
      @(negedge clock);
      queue_mask(node_bit(3, 6), 0, 1'b0);
      queue_mask(node_bit(5, 6), 0, 1'b0);
      queue_mask(node_bit(6, 4), 0, 1'b0);
      queue_mask(node_bit(5, 1), 0, 1'b0);
      queue_mask(node_bit(3, 0), 0, 1'b0);
      queue_mask(node_bit(1, 2), 0, 1'b0);
      queue_mask(node_bit(0, 4), 0, 1'b0);
      queue_mask(node_bit(1, 7), 0, 1'b0);
      queue_mask(node_bit(3, 4), 0, 1'b0);
      queue_mask(node_bit(5, 6) | node_bit(6, 4), 0, 1'b0);
      queue_mask(node_bit(5, 6) | node_bit(6, 4) | node_bit(5, 1), 0, 1'b0);
      queue_mask(node_bit(1, 2) | node_bit(0, 4), 1, 1'b0);
      queue_mask(node_bit(1, 2) | node_bit(0, 4) | node_bit(5, 6), 0, 1'b0);
      queue_mask(node_bit(1, 2) | node_bit(0, 4) | node_bit(5, 1), 0, 1'b0);
      queue_mask(node_bit(5, 6) | node_bit(1, 7), 0, 1'b0);
      queue_mask(node_bit(1, 2) | node_bit(5, 1), 0, 1'b0);
      queue_mask(node_bit(5, 1) | node_bit(3, 0), 0, 1'b0);
      queue_mask(node_bit(1, 7) | node_bit(3, 6), 0, 1'b0);
      queue_mask(node_bit(5, 6) | node_bit(6, 4) | node_bit(5, 1) | node_bit(1, 2), 0, 1'b1);
      wait_idle();

      px = '{3'd7, 3'd0, 3'd7, 3'd0, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
      py = '{3'd7, 3'd7, 3'd0, 3'd0, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph % 2 == 0) begin
            write_csr(CSR_OWN_X, px[ph]);
            write_csr(CSR_OWN_Y, py[ph]);
         end else begin
            write_csr(CSR_OWN_Y, py[ph]);
            write_csr(CSR_OWN_X, px[ph]);
         end
         @(negedge clock);
         for (int k = 0; k < PHASE_ITEMS; k++)
            queue_mask(make_dest_mask(), (k < 30) ? 0 : $urandom_range(0, 6), k == 80);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
